// ----- sv/four_lane_priority_job_queue_core_macros.svh -----
// Assertion macros shared by the job queue checker.
`ifndef FOUR_LANE_PRIORITY_JOB_QUEUE_CORE_MACROS_SVH
`define FOUR_LANE_PRIORITY_JOB_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define FLJQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define FLJQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fljq_pkg.sv -----
// Types and constants of the four-lane priority job queue.
package fljq_pkg;

  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 80;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_DRAIN   = 3'd2,
    MODE_CANCEL  = 3'd3,
    MODE_PEEK    = 3'd4,
    MODE_PROMOTE = 3'd5
  } mode_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] LANE_SESSION = 2'd2;
  localparam logic [1:0] LANE_NEW     = 2'd3;

  typedef struct packed {
    logic load;
    logic push;
    logic head_rd;
    logic head_take;
    logic scan_init;
    logic scan_next_lane;
    logic scan_rd;
    logic scan_miss;
    logic scan_hit;
    logic shift_rd;
    logic shift_wr;
    logic shift_done;
    logic pro_init;
    logic pro_rd;
    logic pro_wr;
    logic pro_done;
    logic finish;
  } fljq_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       has_job;
    logic       scan_end;
    logic       idx_end;
    logic       match;
    logic       shift_end;
    logic       pro_end;
    logic       out_valid;
  } fljq_sts_t;

endpackage

// ----- sv/fljq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fljq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/fljq_ctrl.sv -----
// Sequencer of the job queue: steps each request through the datapath.
module fljq_ctrl import fljq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fljq_sts_t sts_i,
  output fljq_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_DISPATCH  = 10'b00_0000_0010,
    ST_HEAD_WAIT = 10'b00_0000_0100,
    ST_SCAN_RD   = 10'b00_0000_1000,
    ST_SCAN_CHK  = 10'b00_0001_0000,
    ST_SHIFT_RD  = 10'b00_0010_0000,
    ST_SHIFT_WR  = 10'b00_0100_0000,
    ST_PRO_RD    = 10'b00_1000_0000,
    ST_PRO_WR    = 10'b01_0000_0000,
    ST_FINISH    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE) && !sts_i.out_valid;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_ready_o && in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.mode == MODE_PUSH) begin
          cmd_o.push = 1'b1;
          state_d    = ST_FINISH;
        end else if (sts_i.mode inside {MODE_POP, MODE_DRAIN, MODE_PEEK}) begin
          if (sts_i.has_job) begin
            cmd_o.head_rd = 1'b1;
            state_d       = ST_HEAD_WAIT;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (sts_i.mode == MODE_CANCEL) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN_RD;
        end else if (sts_i.mode == MODE_PROMOTE) begin
          cmd_o.pro_init = 1'b1;
          state_d        = ST_PRO_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_HEAD_WAIT: begin
        cmd_o.head_take = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_end) begin
          state_d = ST_FINISH;
        end else if (sts_i.idx_end) begin
          cmd_o.scan_next_lane = 1'b1;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.match) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = ST_SHIFT_RD;
        end else begin
          cmd_o.scan_miss = 1'b1;
          state_d         = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (sts_i.shift_end) begin
          cmd_o.shift_done = 1'b1;
          state_d          = ST_FINISH;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = ST_SHIFT_RD;
      end
      ST_PRO_RD: begin
        if (sts_i.pro_end) begin
          cmd_o.pro_done = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.pro_rd = 1'b1;
          state_d      = ST_PRO_WR;
        end
      end
      ST_PRO_WR: begin
        cmd_o.pro_wr = 1'b1;
        state_d      = ST_PRO_RD;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/fljq_dp.sv -----
// Datapath of the job queue: lane pointers, entry RAM, result register.
module fljq_dp import fljq_pkg::*; #(
  parameter int unsigned LANE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IN_W-1:0]  in_data_i,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  fljq_cmd_t        cmd_i,
  output fljq_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  localparam int unsigned PW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LANE_DEPTH + 1);
  localparam int unsigned NE = 4 * LANE_DEPTH;
  localparam int unsigned AW = $clog2(NE);

  logic [PW-1:0] head_q [4];
  logic [CW-1:0] cnt_q  [4];
  logic [31:0]   thr_q;
  logic          out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic [2:0]    mode_q;
  logic [15:0]   tag_q;
  logic [1:0]    prio_q;
  logic [31:0]   time_q;
  logic [2:0]    lane_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] keep_q;
  logic [CW-1:0] prom_q;
  logic [1:0]    res_status_q;
  logic [15:0]   ftag_q;
  logic [1:0]    flane_q;
  logic [31:0]   ftime_q;

  logic [1:0]    sel_lane;
  logic          has_job;
  logic          push_full;
  logic          pro_ok;
  logic [47:0]   rdata;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] cur_cnt;

  logic          rd_en, wr_en;
  logic [1:0]    rd_lane, wr_lane;
  logic [CW-1:0] rd_off, wr_off;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [47:0]   wr_data;

  function automatic logic [PW-1:0] wrap_slot(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(LANE_DEPTH)) begin
      sum = sum - (CW+1)'(LANE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic [1:0] lane,
                                            input logic [PW-1:0] slot);
    return AW'(lane) * AW'(LANE_DEPTH) + AW'(slot);
  endfunction

  // first non-empty lane; drain pop sees only the top two
  always_comb begin
    has_job  = 1'b0;
    sel_lane = 2'd0;
    for (int l = 3; l >= 0; l--) begin
      if (cnt_q[l] != '0 && (mode_q != MODE_DRAIN || l < 2)) begin
        has_job  = 1'b1;
        sel_lane = 2'(l);
      end
    end
  end

  assign push_full = (cnt_q[prio_q] >= CW'(LANE_DEPTH));
  assign pro_ok    = ((time_q - rdata[47:16]) >= thr_q) &&
                     (cnt_q[LANE_SESSION] < CW'(LANE_DEPTH));
  assign idx_inc   = idx_q + CW'(1);
  assign cur_cnt   = cnt_q[lane_q[1:0]];

  always_comb begin
    rd_lane = sel_lane;
    rd_off  = '0;
    if (cmd_i.scan_rd) begin
      rd_lane = lane_q[1:0];
      rd_off  = idx_q;
    end else if (cmd_i.shift_rd) begin
      rd_lane = lane_q[1:0];
      rd_off  = idx_inc;
    end else if (cmd_i.pro_rd) begin
      rd_lane = LANE_NEW;
      rd_off  = idx_q;
    end
    rd_en   = cmd_i.head_rd | cmd_i.scan_rd | cmd_i.shift_rd | cmd_i.pro_rd;
    rd_addr = mk_addr(rd_lane, wrap_slot(head_q[rd_lane], rd_off));
  end

  always_comb begin
    wr_lane = prio_q;
    wr_off  = cnt_q[prio_q];
    wr_data = {time_q, tag_q};
    wr_en   = cmd_i.push && !push_full;
    if (cmd_i.shift_wr) begin
      wr_lane = lane_q[1:0];
      wr_off  = idx_q;
      wr_data = rdata;
      wr_en   = 1'b1;
    end else if (cmd_i.pro_wr) begin
      wr_data = rdata;
      wr_en   = 1'b1;
      if (pro_ok) begin
        wr_lane = LANE_SESSION;
        wr_off  = cnt_q[LANE_SESSION];
      end else begin
        wr_lane = LANE_NEW;
        wr_off  = keep_q;
      end
    end
    wr_addr = mk_addr(wr_lane, wrap_slot(head_q[wr_lane], wr_off));
  end

  fljq_ram #(
    .WIDTH (48),
    .DEPTH (NE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 4; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
      thr_q       <= 32'd1000;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.push && !push_full) begin
        cnt_q[prio_q] <= cnt_q[prio_q] + CW'(1);
      end
      if (cmd_i.head_take && mode_q != MODE_PEEK) begin
        head_q[sel_lane] <= wrap_slot(head_q[sel_lane], CW'(1));
        cnt_q[sel_lane]  <= cnt_q[sel_lane] - CW'(1);
      end
      if (cmd_i.shift_done) begin
        cnt_q[lane_q[1:0]] <= cur_cnt - CW'(1);
      end
      if (cmd_i.pro_wr && pro_ok) begin
        cnt_q[LANE_SESSION] <= cnt_q[LANE_SESSION] + CW'(1);
      end
      if (cmd_i.pro_done) begin
        cnt_q[LANE_NEW] <= keep_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q       <= in_data_i[2:0];
      tag_q        <= in_data_i[18:3];
      prio_q       <= in_data_i[20:19];
      time_q       <= in_data_i[52:21];
      res_status_q <= STATUS_EMPTY;
      ftag_q       <= '0;
      flane_q      <= '0;
      ftime_q      <= '0;
      prom_q       <= '0;
    end
    if (cmd_i.push) begin
      res_status_q <= push_full ? STATUS_FULL : STATUS_OK;
    end
    if (cmd_i.head_take) begin
      res_status_q <= STATUS_OK;
      ftag_q       <= rdata[15:0];
      ftime_q      <= rdata[47:16];
      flane_q      <= sel_lane;
    end
    if (cmd_i.scan_init) begin
      lane_q <= '0;
      idx_q  <= '0;
    end
    if (cmd_i.scan_next_lane) begin
      lane_q <= lane_q + 3'd1;
      idx_q  <= '0;
    end
    if (cmd_i.scan_miss || cmd_i.shift_wr) begin
      idx_q <= idx_inc;
    end
    if (cmd_i.scan_hit) begin
      res_status_q <= STATUS_OK;
      ftag_q       <= tag_q;
      ftime_q      <= rdata[47:16];
      flane_q      <= lane_q[1:0];
    end
    if (cmd_i.pro_init) begin
      idx_q  <= '0;
      keep_q <= '0;
    end
    if (cmd_i.pro_wr) begin
      idx_q <= idx_inc;
      if (pro_ok) begin
        prom_q <= prom_q + CW'(1);
      end else begin
        keep_q <= keep_q + CW'(1);
      end
    end
    if (cmd_i.pro_done) begin
      res_status_q <= STATUS_OK;
    end
    if (cmd_i.finish) begin
      out_data_q <= {2'b00,
                     (cnt_q[0] != '0) || (cnt_q[1] != '0),
                     5'(cnt_q[3]), 5'(cnt_q[2]), 5'(cnt_q[1]), 5'(cnt_q[0]),
                     5'(prom_q), ftime_q, flane_q, ftag_q, res_status_q};
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.has_job   = has_job;
  assign sts_o.scan_end  = lane_q[2];
  assign sts_o.idx_end   = idx_q >= cur_cnt;
  assign sts_o.match     = rdata[15:0] == tag_q;
  assign sts_o.shift_end = idx_inc >= cur_cnt;
  assign sts_o.pro_end   = idx_q >= cnt_q[LANE_NEW];
  assign sts_o.out_valid = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/four_lane_priority_job_queue_core.sv -----
// Top level of the four-lane strict-priority job queue.
// Four FIFO lanes (control, tool, session, new) of LANE_DEPTH jobs each share one
// 48-bit entry RAM of 4*LANE_DEPTH words; each lane is a ring with a head pointer and
// a count. One request is worked at a time and gives exactly one response. Requests
// are worked by a walk of the single-read-port RAM: push writes the lane tail; pop,
// drain and peek read the head of the first non-empty lane searched; cancel scans the
// lanes in order, compares each entry with the tag and shifts the entries behind the
// match to close the gap; promote walks the new lane and moves each job old enough
// into the session lane while it has room. A new request is taken once the previous
// response has left the output register, so requests never overlap. No clearing pass:
// entries are only read below a lane count.
module four_lane_priority_job_queue_core import fljq_pkg::*; #(
  parameter int unsigned LANE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request: mode[2:0], job_tag[18:3], priority_req[20:19], time_ms[52:21], zero pad
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  // response: status[1:0], found_tag[17:2], found_lane[19:18], found_time[51:20],
  // moved_count[56:52], count_control[61:57], count_tool[66:62],
  // count_session[71:67], count_new[76:72], drain_work[77], zero pad
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,
  // age threshold in ms, write-only
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i
);

  fljq_cmd_t cmd;
  fljq_sts_t sts;

  fljq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fljq_dp #(
    .LANE_DEPTH (LANE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- sv/fljq_checker.sv -----
// Port-level checks of the job queue, bound to the top level.
`include "four_lane_priority_job_queue_core_macros.svh"

module fljq_checker import fljq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  `FLJQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")
  `FLJQ_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
  `FLJQ_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad status code")
  `FLJQ_ASSERT_IMP(a_drain_flag, m_axis_tvalid, m_axis_tdata[77] == ((m_axis_tdata[61:57] != 5'd0) || (m_axis_tdata[66:62] != 5'd0)), "drain flag mismatch")

endmodule

bind four_lane_priority_job_queue_core fljq_checker u_fljq_checker (.*);
